// File: src/mttb_pkg.sv
// ----------------------------------------------------------------------------
// mttb_pkg
// shared types and constants of the millisecond tick timer bank
// ----------------------------------------------------------------------------
`default_nettype none

package mttb_pkg;

   localparam int MS_W       = 32;
   localparam int EPOCH_W    = 8;
   localparam int SLOT_W     = 3;
   localparam int HB_PER_W   = 10;
   localparam int HB_LEFT_W  = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   // request codes
   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_START = 2'd1;
   localparam logic [1:0] REQ_STOP  = 2'd2;
   localparam logic [1:0] REQ_QUERY = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HB_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HB_PERIOD = 2'd1;

   localparam logic [HB_PER_W-1:0] HB_PERIOD_RESET = 10'd500;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [SLOT_W-1:0] slot;
      logic [MS_W-1:0]   timeout_ms;
   } req_payload_type;

   typedef struct packed {
      logic            expired;
      logic [MS_W-1:0] now_ms;
      logic            led_level;
   } rsp_payload_type;

   // controller to datapath
   typedef struct packed {
      logic capture;   // latch the accepted request
      logic execute;   // apply the request and load the result register
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rsp_free;  // result register empty or being taken this cycle
   } dp_status_type;

endpackage

`default_nettype wire

// File: src/mttb_ctrl.sv
// ----------------------------------------------------------------------------
// mttb_ctrl
// request sequencer: accept, execute, hand result to the output register
// ----------------------------------------------------------------------------
`default_nettype none

module mttb_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      mttb_pkg::dp_cmd_type   cmd,
   input  wire mttb_pkg::dp_status_type status
);
   import mttb_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.rsp_free) begin
               cmd.execute  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: src/mttb_datapath.sv
// ----------------------------------------------------------------------------
// mttb_datapath
// time base, heartbeat, deadline slots, registers and result register
// ----------------------------------------------------------------------------
`default_nettype none

module mttb_datapath #(
   parameter int NUM_SLOTS = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire mttb_pkg::dp_cmd_type                cmd,
   output      mttb_pkg::dp_status_type             status,
   input  wire mttb_pkg::req_payload_type           req_payload,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      mttb_pkg::rsp_payload_type           rsp_payload,
   input  wire logic                                csr_valid,
   input  wire logic [mttb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [mttb_pkg::CSR_DATA_W-1:0]     csr_data
);
   import mttb_pkg::*;

   // only slots reachable through the slot field get storage
   localparam int SLOT_MAX   = 1 << SLOT_W;
   localparam int SLOT_DEPTH = (NUM_SLOTS < SLOT_MAX) ? NUM_SLOTS : SLOT_MAX;
   localparam int SLOT_IDX_W = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;

   req_payload_type       req_ff;
   rsp_payload_type       rsp_ff, rsp_in;

   logic [MS_W-1:0]       ms_ff, ms_in;
   logic [EPOCH_W-1:0]    epoch_ff, epoch_in;
   logic [HB_LEFT_W-1:0]  hb_left_ff, hb_left_in;
   logic                  led_ff, led_in;
   logic                  hb_en_ff;
   logic [HB_PER_W-1:0]   hb_per_ff;

   logic [MS_W-1:0]       dl_ff [SLOT_DEPTH];
   logic [EPOCH_W-1:0]    sep_ff [SLOT_DEPTH];

   logic                  slot_ok;
   logic [SLOT_IDX_W-1:0] slot_idx;
   logic [MS_W:0]         dl_sum;
   logic                  wr_en;
   logic [MS_W-1:0]       wr_dl;
   logic [EPOCH_W-1:0]    wr_ep;
   logic [MS_W-1:0]       rd_dl;
   logic [EPOCH_W-1:0]    rd_ep;
   logic                  expired;

   assign slot_ok  = (int'(req_ff.slot) < NUM_SLOTS);
   assign slot_idx = req_ff.slot[SLOT_IDX_W-1:0];
   assign rd_dl    = dl_ff[slot_idx];
   assign rd_ep    = sep_ff[slot_idx];
   assign dl_sum   = {1'b0, ms_ff} + {1'b0, req_ff.timeout_ms};

   always_comb begin
      ms_in      = ms_ff;
      epoch_in   = epoch_ff;
      hb_left_in = hb_left_ff;
      led_in     = led_ff;
      wr_en      = 1'b0;
      wr_dl      = dl_sum[MS_W-1:0];
      wr_ep      = epoch_ff + EPOCH_W'(dl_sum[MS_W]);
      expired    = 1'b0;
      unique case (req_ff.req_type)
         REQ_TICK: begin
            ms_in = ms_ff + 1'b1;
            if (ms_in == '0) begin
               epoch_in = epoch_ff + 1'b1;
            end
            if (hb_en_ff) begin
               if (hb_left_ff <= HB_LEFT_W'(1)) begin
                  led_in     = ~led_ff;
                  hb_left_in = HB_LEFT_W'(hb_per_ff);
               end else begin
                  hb_left_in = hb_left_ff - 1'b1;
               end
            end
         end
         REQ_START: begin
            wr_en = slot_ok;
         end
         REQ_STOP: begin
            wr_en = slot_ok;
            wr_dl = '0;
            wr_ep = '0;
         end
         REQ_QUERY: begin
            expired = slot_ok && ((rd_ep < epoch_ff) ||
                                  ((rd_ep == epoch_ff) && (rd_dl < ms_ff)));
         end
         default: ;
      endcase
      rsp_in.expired   = expired;
      rsp_in.now_ms    = ms_in;
      rsp_in.led_level = led_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_payload;
      end
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ms_ff      <= '0;
         epoch_ff   <= '0;
         hb_left_ff <= '0;
         led_ff     <= 1'b0;
         hb_en_ff   <= 1'b1;
         hb_per_ff  <= HB_PERIOD_RESET;
         for (int i = 0; i < SLOT_DEPTH; i++) begin
            dl_ff[i]  <= '0;
            sep_ff[i] <= '0;
         end
      end else begin
         if (cmd.execute) begin
            ms_ff    <= ms_in;
            epoch_ff <= epoch_in;
            led_ff   <= led_in;
            if (wr_en) begin
               dl_ff[slot_idx]  <= wr_dl;
               sep_ff[slot_idx] <= wr_ep;
            end
         end
         // register writes must come only while idle; not enforced
         if (csr_valid && (csr_index == CSR_HB_ENABLE)) begin
            hb_en_ff <= csr_data[0];
            if (csr_data[0]) begin
               hb_left_ff <= HB_LEFT_W'(hb_per_ff);
            end
         end else if (cmd.execute) begin
            hb_left_ff <= hb_left_in;
         end
         if (csr_valid && (csr_index == CSR_HB_PERIOD)) begin
            hb_per_ff <= csr_data[HB_PER_W-1:0];
         end
      end
   end

   assign status.rsp_free = !rsp_valid || !rsp_stall;
   assign rsp_payload     = rsp_ff;

endmodule

`default_nettype wire

// File: src/millisecond_tick_timer_bank_unit.sv
// ----------------------------------------------------------------------------
// millisecond_tick_timer_bank_unit
// millisecond time base with epoch, heartbeat led and deadline timer slots
// ----------------------------------------------------------------------------
// Each request is first taken into the input register, then applied to the
// time base and slots while the result register is loaded. A new request
// is taken only once the previous one is applied, and applying waits while
// a held result is stalled by the consumer; the controller's two-state
// sequence sets this order. The result register lets the next request be
// taken while a result waits for the consumer. A tick advances the 32-bit
// millisecond count (an 8-bit epoch counts its wraps) and runs the heartbeat
// countdown; start arms a slot with now plus timeout, stop clears a slot,
// query reports whether the slot deadline is behind the current time. Every
// request gives exactly one result carrying the count and the led level.
// Register writes are taken at once and are meant for idle periods only.
// ----------------------------------------------------------------------------
`default_nettype none

module millisecond_tick_timer_bank_unit #(
   parameter int NUM_SLOTS = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire mttb_pkg::req_payload_type           req_payload,
   // result channel
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      mttb_pkg::rsp_payload_type           rsp_payload,
   // register write channel
   input  wire logic                                csr_valid,
   output      logic                                csr_ready,
   input  wire logic [mttb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [mttb_pkg::CSR_DATA_W-1:0]     csr_data
);
   import mttb_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // registers are always writable
   assign csr_ready = 1'b1;

   // sequencer: idle until a request transfer, then execute, which waits while a held result is stalled
   mttb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // time base, heartbeat, slot bank and result register
   mttb_datapath #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   // a request transfer always moves the sequencer to its execute cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken without entering execute");

   // a new result only appears out of the execute cycle
   a_result_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result raised outside execute");

   // execute never overwrites a result still held by the consumer
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && rsp_valid) |-> !rsp_stall)
      else $error("result register overwritten while stalled");

endmodule

`default_nettype wire
